// ----- rtl/pnrs_pkg.sv -----
`timescale 1ns / 1ps

package pnrs_pkg;

    localparam int PNRS_MAX_POINTS = 64;
    localparam int PNRS_COORD_BITS = 16;
    localparam int PNRS_IN_W       = 16;
    localparam int PNRS_RADIUS_W   = 16;
    localparam int PNRS_IDX_W      = 6;
    localparam int PNRS_DIST_W     = 34;
    localparam int PNRS_R2_W       = 2 * PNRS_RADIUS_W;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_INSERT  = 2'd1,
        OP_NEAREST = 2'd2,
        OP_RADIUS  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_NEAREST    = 3'd1,
        ST_MATCH      = 3'd2,
        ST_NO_MATCH   = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_FULL       = 3'd5,
        ST_BAD_RADIUS = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    typedef struct packed {
        t_op                         op;
        logic signed [PNRS_IN_W-1:0] pos_x;
        logic signed [PNRS_IN_W-1:0] pos_y;
        logic [PNRS_RADIUS_W-1:0]    radius;
    } t_cmd;

    typedef struct packed {
        t_status                status;
        logic [PNRS_IDX_W-1:0]  index;
        logic [PNRS_DIST_W-1:0] dist_sq;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic                  hit;
        logic                  fin;
        logic [PNRS_IDX_W-1:0] idx;
    } t_tag;

endpackage

// ----- rtl/pnrs_cell.sv -----
`timescale 1ns / 1ps

module pnrs_cell #(
    parameter int COORD_BITS = pnrs_pkg::PNRS_COORD_BITS
) (
    input  logic                         i_clk,
    input  pnrs_pkg::t_cell_ctl          i_ctl,
    input  logic signed [COORD_BITS-1:0] i_load_x,
    input  logic signed [COORD_BITS-1:0] i_load_y,
    input  logic signed [COORD_BITS-1:0] i_next_x,
    input  logic signed [COORD_BITS-1:0] i_next_y,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);
    import pnrs_pkg::*;

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_ctl.shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ----- rtl/pnrs_dist.sv -----
`timescale 1ns / 1ps

module pnrs_dist #(
    parameter int COORD_BITS = pnrs_pkg::PNRS_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  pnrs_pkg::t_tag               i_tag,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output logic                         o_vld,
    output pnrs_pkg::t_tag               o_tag,
    output logic [2*COORD_BITS+1:0]      o_dist
);
    import pnrs_pkg::*;

    localparam int A_W = COORD_BITS + 1;
    localparam int D_W = 2 * COORD_BITS + 2;

    logic signed [A_W-1:0] dx;
    logic signed [A_W-1:0] dy;
    logic [A_W-1:0]        ax;
    logic [A_W-1:0]        ay;

    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    t_tag           r_t1;
    t_tag           r_t2;
    t_tag           r_t3;
    logic [A_W-1:0] r_ax;
    logic [A_W-1:0] r_ay;
    logic [D_W-1:0] r_sx;
    logic [D_W-1:0] r_sy;
    logic [D_W-1:0] r_d;

    assign dx = A_W'(i_x) - A_W'(i_qx);
    assign dy = A_W'(i_y) - A_W'(i_qy);
    assign ax = dx[A_W-1] ? A_W'(-dx) : A_W'(dx);
    assign ay = dy[A_W-1] ? A_W'(-dy) : A_W'(dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1 <= i_tag;
        r_ax <= ax;
        r_ay <= ay;
        r_t2 <= r_t1;
        r_sx <= D_W'(r_ax) * D_W'(r_ax);
        r_sy <= D_W'(r_ay) * D_W'(r_ay);
        r_t3 <= r_t2;
        r_d  <= r_sx + r_sy;
    end

    assign o_vld  = r_v3;
    assign o_tag  = r_t3;
    assign o_dist = r_d;

endmodule

// ----- rtl/point_nearest_and_radius_search.sv -----
`timescale 1ns / 1ps
// clear, insert, empty-table and zero-radius results come in the next cycle; busy stays low
// queries rotate the ring of MAX_POINTS cells once past a 3-stage distance pipeline:
// the final result is strobed as busy drops, and matches stream out earlier
// one query at a time; a new command is taken only while busy is low
// the receiver cannot stall: every result is strobed for exactly one cycle
// synchronous reset empties the table (count zero); stored coordinates are not cleared
module point_nearest_and_radius_search #(
    parameter int MAX_POINTS = pnrs_pkg::PNRS_MAX_POINTS,
    parameter int COORD_BITS = pnrs_pkg::PNRS_COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pnrs_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output pnrs_pkg::t_result o_result
);
    import pnrs_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int D_W   = 2 * COORD_BITS + 2;
    localparam int CMP_W = (D_W > PNRS_R2_W) ? D_W : PNRS_R2_W;

    function automatic t_result mk_result(t_status st, logic [PNRS_IDX_W-1:0] idx,
                                          logic [PNRS_DIST_W-1:0] dist_v, logic lst);
        t_result res;
        res.status  = st;
        res.index   = idx;
        res.dist_sq = dist_v;
        res.last    = lst;
        return res;
    endfunction

    t_state                       r_state;
    t_state                       n_state;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [CNT_W-1:0]             r_j;
    logic [CNT_W-1:0]             n_j;
    t_op                          r_op;
    t_op                          n_op;
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] n_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic signed [COORD_BITS-1:0] n_qy;
    logic [PNRS_R2_W-1:0]         r_r2;
    logic [PNRS_R2_W-1:0]         n_r2;
    logic                         r_have;
    logic                         n_have;
    logic [D_W-1:0]               r_best_d;
    logic [D_W-1:0]               n_best_d;
    logic [PNRS_IDX_W-1:0]        r_best_i;
    logic [PNRS_IDX_W-1:0]        n_best_i;
    logic                         r_pend;
    logic                         n_pend;
    logic [D_W-1:0]               r_pend_d;
    logic [D_W-1:0]               n_pend_d;
    logic [PNRS_IDX_W-1:0]        r_pend_i;
    logic [PNRS_IDX_W-1:0]        n_pend_i;
    logic                         r_out_vld;
    logic                         n_out_vld;
    t_result                      r_out;
    t_result                      n_out;

    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         full;
    logic                         ins_go;
    logic                         cell_shift;
    logic                         issue_vld;
    t_tag                         issue_tag;
    logic                         res_vld;
    t_tag                         res_tag;
    logic [D_W-1:0]               res_d;

    logic signed [COORD_BITS-1:0] cx [MAX_POINTS];
    logic signed [COORD_BITS-1:0] cy [MAX_POINTS];

    assign in_x   = COORD_BITS'(i_cmd.pos_x);
    assign in_y   = COORD_BITS'(i_cmd.pos_y);
    assign full   = (r_count >= CNT_W'(MAX_POINTS));
    assign ins_go = (r_state == S_IDLE) && start && (i_cmd.op == OP_INSERT) && !full;

    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        t_cell_ctl ctl;

        assign ctl.shift = cell_shift;
        assign ctl.load  = ins_go && (r_count == CNT_W'(k));

        pnrs_cell #(
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_load_x(in_x),
            .i_load_y(in_y),
            .i_next_x(cx[(k + 1) % MAX_POINTS]),
            .i_next_y(cy[(k + 1) % MAX_POINTS]),
            .o_x     (cx[k]),
            .o_y     (cy[k])
        );
    end

    pnrs_dist #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (issue_vld),
        .i_tag  (issue_tag),
        .i_x    (cx[0]),
        .i_y    (cy[0]),
        .i_qx   (r_qx),
        .i_qy   (r_qy),
        .o_vld  (res_vld),
        .o_tag  (res_tag),
        .o_dist (res_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_have    <= 1'b0;
            r_pend    <= 1'b0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_have    <= n_have;
            r_pend    <= n_pend;
            r_j       <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_r2     <= n_r2;
        r_best_d <= n_best_d;
        r_best_i <= n_best_i;
        r_pend_d <= n_pend_d;
        r_pend_i <= n_pend_i;
        r_out    <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_j        = r_j;
        n_op       = r_op;
        n_qx       = r_qx;
        n_qy       = r_qy;
        n_r2       = r_r2;
        n_have     = r_have;
        n_best_d   = r_best_d;
        n_best_i   = r_best_i;
        n_pend     = r_pend;
        n_pend_d   = r_pend_d;
        n_pend_i   = r_pend_i;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        issue_vld  = 1'b0;
        issue_tag  = '0;
        cell_shift = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.op;
                    n_qx   = in_x;
                    n_qy   = in_y;
                    n_r2   = PNRS_R2_W'(i_cmd.radius) * PNRS_R2_W'(i_cmd.radius);
                    n_j    = '0;
                    n_have = 1'b0;
                    n_pend = 1'b0;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_out_vld = 1'b1;
                            n_out     = mk_result(ST_DONE, '0, '0, 1'b1);
                        end
                        OP_INSERT: begin
                            n_out_vld = 1'b1;
                            if (full) begin
                                n_out = mk_result(ST_FULL, '0, '0, 1'b1);
                            end else begin
                                n_count = r_count + 1'b1;
                                n_out   = mk_result(ST_DONE, PNRS_IDX_W'(r_count), '0, 1'b1);
                            end
                        end
                        OP_NEAREST: begin
                            if (r_count == '0) begin
                                n_out_vld = 1'b1;
                                n_out     = mk_result(ST_EMPTY, '0, '0, 1'b1);
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_RADIUS: begin
                            if (i_cmd.radius == '0) begin
                                n_out_vld = 1'b1;
                                n_out     = mk_result(ST_BAD_RADIUS, '0, '0, 1'b1);
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                issue_vld     = 1'b1;
                issue_tag.hit = (r_j < r_count);
                issue_tag.fin = (r_j == CNT_W'(MAX_POINTS));
                issue_tag.idx = PNRS_IDX_W'(r_j);
                cell_shift    = !issue_tag.fin;
                n_j           = r_j + 1'b1;
                if (issue_tag.fin) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_WAIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_vld) begin
            if (r_op == OP_NEAREST) begin
                if (res_tag.fin) begin
                    n_out_vld = 1'b1;
                    n_out     = mk_result(ST_NEAREST, r_best_i, PNRS_DIST_W'(r_best_d), 1'b1);
                    n_state   = S_IDLE;
                end else if (res_tag.hit && (!r_have || res_d < r_best_d)) begin
                    n_have   = 1'b1;
                    n_best_d = res_d;
                    n_best_i = res_tag.idx;
                end
            end else begin
                if (res_tag.fin) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_pend) begin
                        n_out = mk_result(ST_MATCH, r_pend_i, PNRS_DIST_W'(r_pend_d), 1'b1);
                    end else begin
                        n_out = mk_result(ST_NO_MATCH, '0, '0, 1'b1);
                    end
                end else if (res_tag.hit && (CMP_W'(res_d) < CMP_W'(r_r2))) begin
                    if (r_pend) begin
                        n_out_vld = 1'b1;
                        n_out = mk_result(ST_MATCH, r_pend_i, PNRS_DIST_W'(r_pend_d), 1'b0);
                    end
                    n_pend   = 1'b1;
                    n_pend_d = res_d;
                    n_pend_i = res_tag.idx;
                end
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above table size");

    a_final_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid && o_result.last)
        else $error("query finished without a final result");

    a_partial_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("non-final result outside a query");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.op == OP_CLEAR |=>
            o_valid && o_result.last && o_result.status == ST_DONE && r_count == '0)
        else $error("clear transfer not answered next cycle");

endmodule

// ----- dv/point_nearest_and_radius_search_tb.sv -----
`timescale 1ns / 1ps

module point_nearest_and_radius_search_tb;
    import pnrs_pkg::*;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    logic    o_valid;
    t_result o_result;

    point_nearest_and_radius_search i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    t_cmd    cmd_q[$];
    bit      hold_q[$];
    t_result result_q[$];
    t_result want_res;

    logic signed [PNRS_IN_W-1:0] pts_x[PNRS_MAX_POINTS];
    logic signed [PNRS_IN_W-1:0] pts_y[PNRS_MAX_POINTS];
    int unsigned                 pts_count = 0;

    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int quiet = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void queue_result(input t_status st, input int idx,
                                         input longint dist_v, input bit fin);
        t_result r;
        r.status  = st;
        r.index   = PNRS_IDX_W'(idx);
        r.dist_sq = PNRS_DIST_W'(dist_v);
        r.last    = fin;
        result_q.push_back(r);
    endfunction

    function automatic longint sq_dist(input int i, input logic signed [PNRS_IN_W-1:0] qx,
                                       input logic signed [PNRS_IN_W-1:0] qy);
        longint dx;
        longint dy;
        dx = longint'(pts_x[i]) - longint'(qx);
        dy = longint'(pts_y[i]) - longint'(qy);
        return dx * dx + dy * dy;
    endfunction

    function automatic void model_command(input t_cmd c);
        longint d;
        longint best_d;
        longint r2;
        int     best;
        int     hits;
        int     k;
        case (c.op)
            OP_CLEAR: begin
                pts_count = 0;
                queue_result(ST_DONE, 0, 0, 1'b1);
            end
            OP_INSERT: begin
                if (pts_count >= PNRS_MAX_POINTS) begin
                    queue_result(ST_FULL, 0, 0, 1'b1);
                end else begin
                    pts_x[pts_count] = c.pos_x;
                    pts_y[pts_count] = c.pos_y;
                    queue_result(ST_DONE, pts_count, 0, 1'b1);
                    pts_count++;
                end
            end
            OP_NEAREST: begin
                if (pts_count == 0) begin
                    queue_result(ST_EMPTY, 0, 0, 1'b1);
                end else begin
                    best = 0;
                    best_d = sq_dist(0, c.pos_x, c.pos_y);
                    for (int i = 1; i < pts_count; i++) begin
                        d = sq_dist(i, c.pos_x, c.pos_y);
                        if (d < best_d) begin
                            best_d = d;
                            best = i;
                        end
                    end
                    queue_result(ST_NEAREST, best, best_d, 1'b1);
                end
            end
            default: begin
                if (c.radius == 0) begin
                    queue_result(ST_BAD_RADIUS, 0, 0, 1'b1);
                end else begin
                    r2 = longint'(c.radius) * longint'(c.radius);
                    hits = 0;
                    for (int i = 0; i < pts_count; i++) begin
                        if (sq_dist(i, c.pos_x, c.pos_y) < r2) hits++;
                    end
                    if (hits == 0) begin
                        queue_result(ST_NO_MATCH, 0, 0, 1'b1);
                    end else begin
                        k = 0;
                        for (int i = 0; i < pts_count; i++) begin
                            d = sq_dist(i, c.pos_x, c.pos_y);
                            if (d < r2) begin
                                k++;
                                queue_result(ST_MATCH, i, d, k == hits);
                            end
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void add_cmd(input t_op op, input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] r);
        t_cmd c;
        c.op     = op;
        c.pos_x  = x;
        c.pos_y  = y;
        c.radius = r;
        hold_q.push_back(cmd_q.size() == 150 || cmd_q.size() == 300);
        cmd_q.push_back(c);
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3, 4: return 16'($urandom);
            default: return 16'($urandom_range(0, 400)) - 16'd200;
        endcase
    endfunction

    function automatic logic [15:0] rand_radius();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic void add_random_cmd(input bit to_insert);
        int pick;
        pick = $urandom_range(0, 99);
        if (to_insert)
            add_cmd(OP_INSERT, rand_coord(), rand_coord(), 16'($urandom));
        else if (pick < 40)
            add_cmd(OP_NEAREST, rand_coord(), rand_coord(), 16'($urandom));
        else if (pick < 96)
            add_cmd(OP_RADIUS, rand_coord(), rand_coord(), rand_radius());
        else
            add_cmd(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            quiet = 0;
        end else begin
            if (start && !busy) model_command(i_cmd);
            quiet = (result_q.size() == 0 && !busy && !start && !o_valid) ? quiet + 1 : 0;
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (cmd_q.size() != 0 && (!hold_q[0] || quiet > 8)) begin
                    void'(hold_q.pop_front());
                    i_cmd <= cmd_q.pop_front();
                    start <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                flag_mismatch("unexpected result, status", 64'(o_result.status), 0);
            end else begin
                want_res = result_q.pop_front();
                if (o_result.status !== want_res.status)
                    flag_mismatch("status", 64'(o_result.status), 64'(want_res.status));
                if (o_result.index !== want_res.index)
                    flag_mismatch("index", 64'(o_result.index), 64'(want_res.index));
                if (o_result.dist_sq !== want_res.dist_sq)
                    flag_mismatch("dist_sq", 64'(o_result.dist_sq), 64'(want_res.dist_sq));
                if (o_result.last !== want_res.last)
                    flag_mismatch("last", 64'(o_result.last), 64'(want_res.last));
            end
        end
    end

    initial begin
        int fill;
        int ins;
        bit first_seg;

        // empty table, zero radius, extremes, boundary and tie
        add_cmd(OP_NEAREST, 16'd0, 16'd0, 16'd0);
        add_cmd(OP_RADIUS, 16'd0, 16'd0, 16'd5);
        add_cmd(OP_RADIUS, 16'd0, 16'd0, 16'd0);
        add_cmd(OP_INSERT, 16'h7fff, 16'h7fff, 16'd0);
        add_cmd(OP_INSERT, 16'h8000, 16'h8000, 16'hffff);
        add_cmd(OP_INSERT, 16'd3, 16'd4, 16'd0);
        add_cmd(OP_INSERT, 16'h8000, 16'h7fff, 16'd0);
        add_cmd(OP_INSERT, 16'd3, 16'd4, 16'd0);
        add_cmd(OP_NEAREST, 16'd3, 16'd4, 16'd0);
        add_cmd(OP_NEAREST, 16'h7fff, 16'h8000, 16'd0);
        add_cmd(OP_RADIUS, 16'd0, 16'd0, 16'd5);
        add_cmd(OP_RADIUS, 16'd0, 16'd0, 16'd6);
        add_cmd(OP_RADIUS, 16'd0, 16'd0, 16'hffff);
        add_cmd(OP_RADIUS, 16'h7fff, 16'h8000, 16'd0);
        add_cmd(OP_CLEAR, 16'd0, 16'd0, 16'd0);
        add_cmd(OP_INSERT, 16'h8000, 16'h8000, 16'd0);
        add_cmd(OP_NEAREST, 16'h7fff, 16'h7fff, 16'd0);
        add_cmd(OP_RADIUS, 16'h7fff, 16'h7fff, 16'hffff);
        add_cmd(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff);
        add_cmd(OP_NEAREST, 16'd0, 16'd0, 16'd0);

        // random segments: clear, fill to a random depth with queries mixed in
        first_seg = 1'b1;
        while (cmd_q.size() < 380) begin
            add_cmd(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
            fill = (first_seg || $urandom_range(0, 3) == 0) ? 68 : $urandom_range(1, 24);
            first_seg = 1'b0;
            ins = 0;
            while (ins < fill && cmd_q.size() < 380) begin
                if ($urandom_range(0, 1) == 0) begin
                    add_random_cmd(1'b1);
                    ins++;
                end else begin
                    add_random_cmd(1'b0);
                end
            end
            repeat ($urandom_range(1, 4)) add_random_cmd(1'b0);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || start) @(posedge i_clk);
        for (int k = 0; k < 20000 && result_q.size() != 0; k++) @(posedge i_clk);
        repeat (PNRS_MAX_POINTS + 16) @(posedge i_clk);
        if (result_q.size() != 0)
            flag_mismatch("results never seen, count", 64'(result_q.size()), 0);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
